[design/als_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_pkg
// Types and constants shared by the LED strip serializer modules.
// ----------------------------------------------------------------------------
package als_pkg;

   // Request kind codes
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_PIXEL_TOTAL = 3'd0;
   localparam logic [2:0] CSR_BIT_TICKS   = 3'd1;
   localparam logic [2:0] CSR_ONE_HIGH    = 3'd2;
   localparam logic [2:0] CSR_ZERO_HIGH   = 3'd3;
   localparam logic [2:0] CSR_LATCH       = 3'd4;

   localparam int CSR_DATA_W = 13;

   // Reset values of the configuration registers
   localparam logic [8:0]  PIXEL_TOTAL_RST = 9'd16;
   localparam logic [7:0]  BIT_TICKS_RST   = 8'd58;
   localparam logic [7:0]  ONE_HIGH_RST    = 8'd29;
   localparam logic [7:0]  ZERO_HIGH_RST   = 8'd14;
   localparam logic [12:0] LATCH_RST       = 13'd4320;

   // Each pixel carries 24 bits: green, red, blue, msb first
   localparam logic [4:0] LAST_BIT = 5'd23;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] pixel_index;
      logic [7:0] red_value;
      logic [7:0] green_value;
      logic [7:0] blue_value;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_TICK  = 4'b0001,
      OP_WRITE = 4'b0010,
      OP_START = 4'b0100,
      OP_NOP   = 4'b1000
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        index_ok;
      logic [7:0]  pixel_index;
      logic [23:0] pixel;
   } cmd_type;

   typedef struct packed {
      logic [8:0]  pixel_total;
      logic [7:0]  bit_ticks;
      logic [7:0]  one_high_ticks;
      logic [7:0]  zero_high_ticks;
      logic [12:0] latch_ticks;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_SEND  = 3'b010,
      PH_LATCH = 3'b100
   } phase_type;

endpackage

[design/als_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_front
// Accepts request transfers, decodes the kind and range-checks the pixel
// index, and holds the decoded command until the queue takes it.
// ----------------------------------------------------------------------------
module als_front
   import als_pkg::*;
#(
   parameter int MAX_PIXELS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    queue_full
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept, move;

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign move      = valid_ff && !queue_full;

   always_comb begin
      cmd_in.pixel_index = req_payload.pixel_index;
      cmd_in.pixel       = {req_payload.green_value, req_payload.red_value,
                            req_payload.blue_value};
      cmd_in.index_ok    = (32'(req_payload.pixel_index) < MAX_PIXELS);
      unique case (req_payload.kind)
         KIND_TICK:  cmd_in.op = OP_TICK;
         KIND_WRITE: cmd_in.op = OP_WRITE;
         KIND_START: cmd_in.op = OP_START;
         default:    cmd_in.op = OP_NOP;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (move) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

[design/als_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_queue
// Short command queue that decouples the decode front from the line engine.
// ----------------------------------------------------------------------------
module als_queue
   import als_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_data,
   input  logic    pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/als_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_back
// Line engine: pixel store, bit and pulse timing, latch period and the
// response register.
// ----------------------------------------------------------------------------
module als_back
   import als_pkg::*;
#(
   parameter int MAX_PIXELS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int PCW = $clog2(MAX_PIXELS + 1);

   logic [23:0]   mem [MAX_PIXELS];
   logic [23:0]   rd_data_ff;

   phase_type     phase_ff, phase_in;
   logic [PCW-1:0] pc_ff, pc_in;
   logic [4:0]    bc_ff, bc_in;
   logic [12:0]   tc_ff, tc_in;
   logic [23:0]   shift_ff, shift_in;
   logic          line_ff, line_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          take;
   logic          mem_we;
   logic [AW-1:0] waddr, raddr;
   logic [PCW-1:0] frame_len, pc_inc;
   logic [7:0]    high_ticks;
   logic [12:0]   tc_inc;
   logic          done, rej;

   assign take    = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign cmd_pop = take;

   assign frame_len = (32'(cfg.pixel_total) > MAX_PIXELS) ? PCW'(MAX_PIXELS)
                                                          : PCW'(cfg.pixel_total);
   assign pc_inc = pc_ff + 1'b1;
   assign tc_inc = tc_ff + 1'b1;
   assign waddr  = AW'(cmd_data.pixel_index);

   // Prefetch the pixel that follows the one on the line; pixel 0 while idle
   always_comb begin
      raddr = '0;
      if (phase_ff == PH_SEND && 32'(pc_inc) < MAX_PIXELS) begin
         raddr = AW'(pc_inc);
      end
   end

   always_comb begin
      high_ticks = shift_ff[23] ? cfg.one_high_ticks : cfg.zero_high_ticks;
      if (high_ticks > cfg.bit_ticks) begin
         high_ticks = cfg.bit_ticks;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      pc_in    = pc_ff;
      bc_in    = bc_ff;
      tc_in    = tc_ff;
      shift_in = shift_ff;
      line_in  = line_ff;
      mem_we   = 1'b0;
      done     = 1'b0;
      rej      = 1'b0;
      if (take) begin
         unique case (cmd_data.op)
            OP_TICK: begin
               unique case (phase_ff)
                  PH_SEND: begin
                     line_in = (tc_ff < 13'(high_ticks));
                     if (tc_inc >= 13'(cfg.bit_ticks)) begin
                        tc_in    = '0;
                        shift_in = {shift_ff[22:0], 1'b0};
                        bc_in    = bc_ff + 1'b1;
                        if (bc_ff == LAST_BIT) begin
                           pc_in = pc_inc;
                           if (pc_inc >= frame_len) begin
                              phase_in = PH_LATCH;
                              line_in  = 1'b0;
                           end else begin
                              shift_in = rd_data_ff;
                              bc_in    = '0;
                           end
                        end
                     end else begin
                        tc_in = tc_inc;
                     end
                  end
                  PH_LATCH: begin
                     line_in = 1'b0;
                     if (tc_inc >= cfg.latch_ticks || tc_inc == '0) begin
                        phase_in = PH_IDLE;
                        tc_in    = '0;
                        pc_in    = '0;
                        bc_in    = '0;
                        done     = 1'b1;
                     end else begin
                        tc_in = tc_inc;
                     end
                  end
                  default: begin
                     line_in = 1'b0;
                  end
               endcase
            end
            OP_WRITE: begin
               if (phase_ff != PH_IDLE || !cmd_data.index_ok) begin
                  rej = 1'b1;
               end else begin
                  mem_we = 1'b1;
               end
            end
            OP_START: begin
               if (phase_ff != PH_IDLE) begin
                  rej = 1'b1;
               end else begin
                  pc_in = '0;
                  tc_in = '0;
                  if (frame_len == '0) begin
                     phase_in = PH_LATCH;
                     line_in  = 1'b0;
                  end else begin
                     phase_in = PH_SEND;
                     shift_in = rd_data_ff;
                     bc_in    = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.line_level = line_in;
      rsp_in.busy_res   = (phase_in != PH_IDLE);
      rsp_in.frame_done = done;
      rsp_in.rejected   = rej;
      rsp_valid_in      = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pc_ff        <= '0;
         bc_ff        <= '0;
         tc_ff        <= '0;
         shift_ff     <= '0;
         line_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pc_ff        <= pc_in;
         bc_ff        <= bc_in;
         tc_ff        <= tc_in;
         shift_ff     <= shift_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   // Pixel store; forward a same-cycle write so a start right after it sees it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= cmd_data.pixel;
      end
      rd_data_ff <= (mem_we && waddr == raddr) ? cmd_data.pixel : mem[raddr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> phase_ff == PH_IDLE)
      else $error("pixel store written during a frame");

   a_line_only_in_send: assert property (@(posedge clock) disable iff (reset)
      line_ff |-> phase_ff == PH_SEND)
      else $error("line high outside the send phase");

   // The count runs one past the last bit once the frame ends
   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEND) |-> bc_ff <= LAST_BIT)
      else $error("bit counter past the last bit of a pixel");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (take && done) |=> rsp_valid_ff && !rsp_ff.busy_res && !rsp_ff.rejected)
      else $error("frame done reported with busy or rejected set");

endmodule

[design/addressable_led_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_serializer
// Single-wire addressable LED strip driver: pixel store, frame serializer
// with programmable bit timing and latch period.
// Path: decode register, command queue, then the response register.
// Throughput: one request per cycle unless stalled; the line engine handles
//   one command per cycle while rsp_stall is low and reads the next pixel
//   ahead from the store's read port.
// Reset: synchronous; engine idle, line low, registers at their defaults.
//   The pixel store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module addressable_led_serializer
   import als_pkg::*;
#(
   parameter int MAX_PIXELS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    front_valid;
   cmd_type front_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_TOTAL: cfg_in.pixel_total     = csr_wdata[8:0];
            CSR_BIT_TICKS:   cfg_in.bit_ticks       = csr_wdata[7:0];
            CSR_ONE_HIGH:    cfg_in.one_high_ticks  = csr_wdata[7:0];
            CSR_ZERO_HIGH:   cfg_in.zero_high_ticks = csr_wdata[7:0];
            CSR_LATCH:       cfg_in.latch_ticks     = csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_total     <= PIXEL_TOTAL_RST;
         cfg_ff.bit_ticks       <= BIT_TICKS_RST;
         cfg_ff.one_high_ticks  <= ONE_HIGH_RST;
         cfg_ff.zero_high_ticks <= ZERO_HIGH_RST;
         cfg_ff.latch_ticks     <= LATCH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   als_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (front_valid),
      .cmd_data    (front_cmd),
      .queue_full  (queue_full)
   );

   als_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_cmd),
      .pop        (head_pop)
   );

   als_back #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd_valid   (head_valid),
      .cmd_data    (head_cmd),
      .cmd_pop     (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
